/* sv/greedy_graph_coloring_assert.svh */
// Assertion macros for the greedy graph coloring block.
`ifndef GREEDY_GRAPH_COLORING_ASSERT_SVH
`define GREEDY_GRAPH_COLORING_ASSERT_SVH

// Property that holds in the same cycle.
`define GGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define GGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ggc_pkg.sv */
// Package with widths, codes and state type of the greedy graph coloring block.
package ggc_pkg;

  localparam int OP_W           = 2;
  localparam int VTX_W          = 6;
  localparam int COLOR_W        = 6;
  localparam int VCNT_W         = 7;
  localparam int APB_DW         = 32;
  localparam int PADDR_W        = 3;
  localparam int MAX_VERTICES_DEF = 64;

  localparam logic [VCNT_W-1:0] VCNT_RST = 7'd64;

  // Register index, taken from paddr[2]
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_RUN      = 2'd1,
    OP_CLEAR    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_WALK,
    ST_DRAIN,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } state_e;

endpackage

/* sv/greedy_graph_coloring.sv */
// Greedy graph coloring: add-edge and clear transfers are taken while the block is idle.
// A run handles each vertex u > 0 by a row read, a neighbour walk through the
// colour memory read port, a drain, then a scan for the lowest free colour c; vertex 0
// goes from the row read straight to the scan. Each result is read, loaded and held until taken.
// Reset empties the graph at once (row valid flops) and sets vertex_count to 64;
// the block takes transfers from the first cycle after reset.
`include "greedy_graph_coloring_assert.svh"

module greedy_graph_coloring
  import ggc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [VTX_W-1:0]     vertex_a_i,
  input  logic [VTX_W-1:0]     vertex_b_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [VTX_W-1:0]     vertex_o,
  output logic [COLOR_W-1:0]   color_o,
  output logic                 last_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  localparam int NV = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
  localparam int IW = $clog2(NV);

  state_e state_q, state_d;

  logic [VCNT_W-1:0] vcount_q;
  logic [VCNT_W-1:0] v_eff;
  logic [IW-1:0]     vlast;

  logic [NV-1:0]     adj_mem [NV];
  logic [NV-1:0]     row_vld_q;
  logic [NV-1:0]     adj_rd_q;
  logic              row_ok_q;
  logic [NV-1:0]     row_bits;

  logic [IW-1:0]     col_mem [NV];
  logic [IW-1:0]     col_rd_q;
  logic [IW-1:0]     col_raddr;

  logic [NV-1:0]     used_q;
  logic              hit_q;
  logic [IW-1:0]     u_q, n_q, c_q, o_q;

  logic              out_valid_q, last_q;
  logic [VTX_W-1:0]  vertex_q;
  logic [COLOR_W-1:0] color_q;

  logic              in_acc, out_acc, cfg_we;
  logic              edge_ok, edge_we, clear_graph, run_start, found;
  logic [IW-1:0]     a_ix, b_ix, hi_ix, lo_ix;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready & (paddr[2] == REG_VERTEX_COUNT);
  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? APB_DW'(vcount_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCNT_RST;
    end else if (cfg_we) begin
      vcount_q <= pwdata[VCNT_W-1:0];
    end
  end

  always_comb begin
    if (vcount_q == '0) begin
      v_eff = VCNT_W'(1);
    end else if (vcount_q > VCNT_W'(NV)) begin
      v_eff = VCNT_W'(NV);
    end else begin
      v_eff = vcount_q;
    end
  end
  assign vlast = IW'(v_eff - VCNT_W'(1));

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_q & ~out_stall_i;

  assign a_ix  = vertex_a_i[IW-1:0];
  assign b_ix  = vertex_b_i[IW-1:0];
  assign hi_ix = (a_ix > b_ix) ? a_ix : b_ix;
  assign lo_ix = (a_ix > b_ix) ? b_ix : a_ix;
  // only the lower neighbour of the higher endpoint matters; self loops never count
  assign edge_ok = (VCNT_W'(vertex_a_i) < v_eff) && (VCNT_W'(vertex_b_i) < v_eff) &&
                   (a_ix != b_ix);

  assign row_bits = row_ok_q ? adj_rd_q : '0;
  assign found    = ~used_q[c_q];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_acc && (op_i == OP_RUN)) state_d = ST_ROW;
      ST_ROW:       state_d = (u_q == '0) ? ST_SCAN : ST_WALK;
      ST_WALK:      if (n_q == u_q - IW'(1)) state_d = ST_DRAIN;
      ST_DRAIN:     state_d = ST_SCAN;
      ST_SCAN:      if (found) state_d = (u_q == vlast) ? ST_EMIT_RD : ST_ROW;
      ST_EMIT_RD:   state_d = ST_EMIT_LD;
      ST_EMIT_LD:   state_d = ST_EMIT_HOLD;
      ST_EMIT_HOLD: if (!out_stall_i) state_d = (o_q == vlast) ? ST_IDLE : ST_EMIT_RD;
      default:      state_d = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    edge_we     = (state_q == ST_IDLE) && in_valid_i && (op_i == OP_ADD_EDGE) && edge_ok;
    clear_graph = (state_q == ST_IDLE) && in_valid_i && (op_i == OP_CLEAR);
    run_start   = (state_q == ST_IDLE) && in_valid_i && (op_i == OP_RUN);
    col_raddr   = (state_q == ST_EMIT_RD) ? o_q : n_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // adjacency rows, lower neighbours only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (clear_graph) begin
      row_vld_q <= '0;
    end else if (edge_we) begin
      row_vld_q[hi_ix] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      if (!row_vld_q[hi_ix]) begin
        adj_mem[hi_ix] <= NV'(1) << lo_ix;
      end else begin
        adj_mem[hi_ix][lo_ix] <= 1'b1;
      end
    end
    adj_rd_q <= adj_mem[u_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROW) begin
      row_ok_q <= row_vld_q[u_q];
    end
  end

  // colour memory
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && found) begin
      col_mem[u_q] <= c_q;
    end
    col_rd_q <= col_mem[col_raddr];
  end

  // sequencer counters and used-colour mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q    <= '0;
      n_q    <= '0;
      c_q    <= '0;
      o_q    <= '0;
      hit_q  <= 1'b0;
      used_q <= '0;
    end else begin
      hit_q <= (state_q == ST_WALK) && row_bits[n_q];
      if (hit_q) begin
        used_q[col_rd_q] <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (run_start) u_q <= '0;
        end
        ST_ROW: begin
          n_q <= '0;
          c_q <= '0;
        end
        ST_WALK: n_q <= n_q + IW'(1);
        ST_DRAIN: c_q <= '0;
        ST_SCAN: begin
          if (found) begin
            used_q <= '0;
            o_q    <= '0;
            u_q    <= u_q + IW'(1);
          end else begin
            c_q <= c_q + IW'(1);
          end
        end
        ST_EMIT_HOLD: begin
          if (out_acc) o_q <= o_q + IW'(1);
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT_LD) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT_LD) begin
      vertex_q <= VTX_W'(o_q);
      color_q  <= COLOR_W'(col_rd_q);
      last_q   <= (o_q == vlast);
    end
  end

  assign out_valid_o = out_valid_q;
  assign vertex_o    = vertex_q;
  assign color_o     = color_q;
  assign last_o      = last_q;

  `GGC_ASSERT(a_no_input_while_result, out_valid_o |-> in_stall_o, "input taken with result pending")
  `GGC_ASSERT(a_color_bound, (state_q == ST_SCAN) |-> (c_q <= u_q), "colour search ran past vertex index")
  `GGC_ASSERT_NEXT(a_run_busy, in_acc && (op_i == OP_RUN), in_stall_o, "run did not block input")
  `GGC_ASSERT_NEXT(a_last_ends_run, out_acc && last_o, state_q == ST_IDLE, "run continued past last result")

endmodule

/* tb/ggc_checker.sv */
// Checker for the greedy graph colouring block: tracks graph and vertex count, predicts colourings.
`timescale 1ns / 100ps

module ggc_checker
  import ggc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [VTX_W-1:0]     vertex_a_i,
  input  logic [VTX_W-1:0]     vertex_b_i,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  logic [VTX_W-1:0]     vertex_o,
  input  logic [COLOR_W-1:0]   color_o,
  input  logic                 last_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [APB_DW-1:0]    pwdata,
  input  logic                 pready,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [VTX_W-1:0]   vertex;
    logic [COLOR_W-1:0] color;
    logic               last;
  } colouring_t;

  logic [63:0]       adj_rows [MAX_VERTICES_DEF];
  logic [VCNT_W-1:0] vcount;
  colouring_t        colouring_q [$];

  initial fail_count = 0;

  function automatic int unsigned active_vertices();
    if (vcount == '0) return 1;
    if (vcount > MAX_VERTICES_DEF) return MAX_VERTICES_DEF;
    return 32'(vcount);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic predict_colouring();
    int unsigned      nv;
    logic [5:0]       hue [MAX_VERTICES_DEF];
    logic [63:0]      lower;
    logic [63:0]      taken;
    int unsigned      c;
    colouring_t       res;
    nv = active_vertices();
    hue[0] = '0;
    for (int unsigned u = 1; u < nv; u++) begin
      lower = adj_rows[u] & ((64'd1 << u) - 64'd1);
      taken = '0;
      for (int unsigned n = 0; n < u; n++)
        if (lower[n]) taken[hue[n]] = 1'b1;
      c = 0;
      while (c < 63 && taken[c]) c++;
      hue[u] = c[5:0];
    end
    for (int unsigned u = 0; u < nv; u++) begin
      res.vertex = u[VTX_W-1:0];
      res.color  = hue[u];
      res.last   = (u + 1 == nv);
      colouring_q.insert(colouring_q.size(), res);
    end
  endtask

  task automatic apply_item();
    int unsigned nv;
    nv = active_vertices();
    case (op_i)
      OP_ADD_EDGE: begin
        if (vertex_a_i < nv && vertex_b_i < nv) begin
          adj_rows[vertex_a_i][vertex_b_i] = 1'b1;
          adj_rows[vertex_b_i][vertex_a_i] = 1'b1;
        end
      end
      OP_CLEAR: foreach (adj_rows[i]) adj_rows[i] = '0;
      OP_RUN:   predict_colouring();
      default:  ;
    endcase
  endtask

  task automatic check_result();
    colouring_t want;
    if (colouring_q.size() == 0) begin
      report_mismatch("unexpected result, vertex", int'(vertex_o), -1);
      return;
    end
    want = colouring_q.pop_front();
    if (vertex_o !== want.vertex)
      report_mismatch("vertex", int'(vertex_o), int'(want.vertex));
    if (color_o !== want.color)
      report_mismatch("colour", int'(color_o), int'(want.color));
    if (last_o !== want.last)
      report_mismatch("last", int'(last_o), int'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (adj_rows[i]) adj_rows[i] = '0;
      vcount = VCNT_RST;
      colouring_q.delete();
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_VERTEX_COUNT)
        vcount = pwdata[VCNT_W-1:0];
      if (out_valid_o && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_o) apply_item();
      pending = colouring_q.size();
    end
  end

endmodule

/* tb/tb.sv */
// Testbench top for the greedy graph colouring block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
  import ggc_pkg::*;

  localparam int CYCLE_LIMIT  = 5000000;
  localparam int IDLE_SETTLE  = 16;
  localparam int DRAIN_CYCLES = 64;
  localparam int ITEM_TARGET  = 120;

  localparam logic [OP_W-1:0]    OP_UNUSED         = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_VERTEX_COUNT = {REG_VERTEX_COUNT, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNUSED       = {~REG_VERTEX_COUNT, 2'b00};

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [OP_W-1:0]      op_i;
  logic [VTX_W-1:0]     vertex_a_i;
  logic [VTX_W-1:0]     vertex_b_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [VTX_W-1:0]     vertex_o;
  logic [COLOR_W-1:0]   color_o;
  logic                 last_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  int  fail_count;
  int  pending;
  int  cycle_count = 0;
  int  stall_hold = 0;
  bit  quiet = 1'b0;

  always #2 clk_i = ~clk_i;

  greedy_graph_coloring dut (.*);

  ggc_checker checker_i (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    int r;
    if (stall_hold > 0) begin
      stall_hold--;
    end else if (quiet || !rst_ni) begin
      out_stall_i = 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_stall_i = 1'b0;
        stall_hold = $urandom_range(0, 4);
      end else if (r < 90) begin
        out_stall_i = 1'b1;
        stall_hold = $urandom_range(0, 3);
      end else begin
        out_stall_i = 1'b1;
        stall_hold = $urandom_range(10, 30);
      end
    end
  end

  function automatic int gap_cycles();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(logic [OP_W-1:0] op, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i       = op;
    vertex_a_i = a;
    vertex_b_i = b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (IDLE_SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [APB_DW-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  initial begin
    int          items_done;
    int          vsel;
    int          nv;
    int          edges;
    int          sequences;
    int          pick;
    logic [31:0] data;
    logic [5:0]  a;
    logic [5:0]  b;
    logic [1:0]  op;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    op_i       = OP_ADD_EDGE;
    vertex_a_i = '0;
    vertex_b_i = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset vertex count of 64
    send_item(OP_ADD_EDGE, 6'd0, 6'd63);
    send_item(OP_ADD_EDGE, 6'd63, 6'd62);
    send_item(OP_ADD_EDGE, 6'd1, 6'd0);
    send_item(OP_ADD_EDGE, 6'd2, 6'd0);
    send_item(OP_ADD_EDGE, 6'd2, 6'd1);
    send_item(OP_ADD_EDGE, 6'd5, 6'd5);
    send_item(OP_UNUSED, 6'd63, 6'd63);
    send_item(OP_RUN, 6'd63, 6'd0);
    send_item(OP_CLEAR, 6'd0, 6'd0);
    send_item(OP_RUN, 6'd0, 6'd0);

    // zero vertex count acts as one
    wait_idle();
    write_reg(ADDR_VERTEX_COUNT, 32'd0);
    send_item(OP_ADD_EDGE, 6'd0, 6'd1);
    send_item(OP_ADD_EDGE, 6'd0, 6'd0);
    send_item(OP_RUN, 6'd0, 6'd0);

    wait_idle();
    write_reg(ADDR_VERTEX_COUNT, 32'd3);
    send_item(OP_ADD_EDGE, 6'd2, 6'd3);
    send_item(OP_ADD_EDGE, 6'd0, 6'd1);
    send_item(OP_ADD_EDGE, 6'd1, 6'd2);
    send_item(OP_RUN, 6'd0, 6'd0);

    // edges above a smaller count stay stored
    wait_idle();
    write_reg(ADDR_VERTEX_COUNT, 32'd2);
    send_item(OP_RUN, 6'd0, 6'd0);

    wait_idle();
    write_reg(ADDR_VERTEX_COUNT, 32'hffff_ffff);
    send_item(OP_RUN, 6'd0, 6'd0);

    wait_idle();
    write_reg(ADDR_UNUSED, 32'd5);
    send_item(OP_RUN, 6'd0, 6'd0);
    send_item(OP_CLEAR, 6'd0, 6'd0);

    // random phases
    items_done = 0;
    while (items_done < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       vsel = 64;
        1:       vsel = 0;
        2:       vsel = $urandom_range(65, 127);
        default: vsel = $urandom_range(1, 16);
      endcase
      nv = (vsel == 0) ? 1 : (vsel > 64) ? 64 : vsel;
      data = $urandom();
      if ($urandom_range(0, 1) == 0) data[31:7] = '0;
      data[6:0] = vsel[6:0];
      wait_idle();
      quiet = ($urandom_range(0, 3) == 0);
      write_reg(ADDR_VERTEX_COUNT, data);

      sequences = $urandom_range(1, 3);
      repeat (sequences) begin
        if ($urandom_range(0, 3) != 0) begin
          send_item(OP_CLEAR, 6'($urandom()), 6'($urandom()));
          items_done++;
        end
        edges = $urandom_range(0, (nv < 14) ? 3 * nv : 40);
        repeat (edges) begin
          if ($urandom_range(0, 9) == 0) begin
            a  = 6'($urandom_range(0, 63));
            b  = 6'($urandom_range(0, 63));
            op = ($urandom_range(0, 1) == 0) ? OP_UNUSED : OP_ADD_EDGE;
          end else begin
            a  = 6'($urandom_range(0, nv - 1));
            b  = 6'($urandom_range(0, nv - 1));
            op = OP_ADD_EDGE;
          end
          send_item(op, a, b);
          items_done++;
        end
        send_item(OP_RUN, 6'($urandom()), 6'($urandom()));
        items_done++;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/ggc_pkg.sv
sv/greedy_graph_coloring.sv
tb/ggc_checker.sv
tb/tb.sv
